FILE: src/assert_macros.svh
// Assertion macros shared by the ray-march block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/grmp_pkg.sv
// Package: types, constants and helpers of the grid ray-march block
package grmp_pkg;

  localparam int DEF_MAX_CELLS  = 65536;
  localparam int DEF_FLAG_BITS  = 16;
  localparam int DEF_BLOCK_MASK = 2;
  localparam int DEF_MAX_STEPS  = 4096;

  localparam int EPS_Q16 = 1311;

  localparam int SUM_W    = 18;
  localparam int MOD_STEP = 6;
  localparam int MOD_CYC  = 3;

  localparam logic [2:0] REG_CELLS_X   = 3'd0;
  localparam logic [2:0] REG_CELLS_Z   = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_MIN_X     = 3'd3;
  localparam logic [2:0] REG_MIN_Y     = 3'd4;
  localparam logic [2:0] REG_MIN_Z     = 3'd5;
  localparam logic [2:0] REG_SCALE_X   = 3'd6;
  localparam logic [2:0] REG_SCALE_Z   = 3'd7;

  typedef struct packed {
    logic load;
    logic latch;
    logic mul_x;
    logic mul_z;
    logic set_z;
    logic idx;
    logic adr;
    logic mod;
    logic rd;
    logic step;
    logic hx;
    logic hz;
    logic res_miss;
    logic res_orig;
    logic res_hit;
  } cmd_t;

  typedef struct packed {
    logic short_ray;
    logic blocked;
    logic first;
    logic walk_end;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v[49] && !(&v[48:31])) begin
      return 32'sh8000_0000;
    end else if (!v[49] && (|v[48:31])) begin
      return 32'sh7fff_ffff;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [8:0] cell_idx(input logic signed [31:0] pos,
                                          input logic [8:0] n);
    logic [14:0] c;
    c = pos[30:16];
    if (pos[31]) begin
      return 9'd0;
    end else if (c >= {6'd0, n}) begin
      return n - 9'd1;
    end else begin
      return c[8:0];
    end
  endfunction

endpackage

FILE: src/grmp_ram.sv
// Generic single-write, single-read RAM with registered read data
module grmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/grmp_ctrl.sv
// Controller: sequences setup, cell walk, table reads and result issue
module grmp_ctrl
  import grmp_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  mode,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  localparam bit POW2 = (MAX_CELLS > 1) && ((MAX_CELLS & (MAX_CELLS - 1)) == 0);
  localparam int MCW  = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL_X = 4'd1;
  localparam logic [3:0] ST_MUL_Z = 4'd2;
  localparam logic [3:0] ST_SET_Z = 4'd3;
  localparam logic [3:0] ST_IDX   = 4'd4;
  localparam logic [3:0] ST_ADR   = 4'd5;
  localparam logic [3:0] ST_MOD   = 4'd6;
  localparam logic [3:0] ST_RD    = 4'd7;
  localparam logic [3:0] ST_CHK   = 4'd8;
  localparam logic [3:0] ST_HX    = 4'd9;
  localparam logic [3:0] ST_HZ    = 4'd10;
  localparam logic [3:0] ST_HFIN  = 4'd11;

  logic [3:0]     state, state_next;
  logic [MCW-1:0] mcnt, mcnt_next;
  logic           done_next;
  logic           accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    mcnt_next  = mcnt;
    done_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && !mode) begin
          cmd.load = 1'b1;
        end else if (accept && mode) begin
          cmd.latch = 1'b1;
          if (stat.short_ray) begin
            cmd.res_miss = 1'b1;
            done_next    = 1'b1;
          end else begin
            state_next = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd.mul_z  = 1'b1;
        state_next = ST_SET_Z;
      end
      ST_SET_Z: begin
        cmd.set_z  = 1'b1;
        state_next = ST_IDX;
      end
      ST_IDX: begin
        cmd.idx    = 1'b1;
        state_next = ST_ADR;
      end
      ST_ADR: begin
        cmd.adr    = 1'b1;
        mcnt_next  = '0;
        state_next = POW2 ? ST_RD : ST_MOD;
      end
      ST_MOD: begin
        cmd.mod   = 1'b1;
        mcnt_next = MCW'(mcnt + 1'b1);
        if (mcnt == MCW'(MOD_CYC - 1)) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (stat.blocked && stat.first) begin
          cmd.res_orig = 1'b1;
          done_next    = 1'b1;
          state_next   = ST_IDLE;
        end else if (stat.blocked) begin
          state_next = ST_HX;
        end else begin
          cmd.step = 1'b1;
          if (stat.walk_end) begin
            cmd.res_miss = 1'b1;
            done_next    = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_IDX;
          end
        end
      end
      ST_HX: begin
        cmd.hx     = 1'b1;
        state_next = ST_HZ;
      end
      ST_HZ: begin
        cmd.hz     = 1'b1;
        state_next = ST_HFIN;
      end
      ST_HFIN: begin
        cmd.res_hit = 1'b1;
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mcnt  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mcnt  <= mcnt_next;
      done  <= done_next;
    end
  end

endmodule

FILE: src/grmp_dp.sv
// Datapath: config registers, grid mapping, walk arithmetic and result registers
module grmp_dp
  import grmp_pkg::*;
#(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int FLAG_BITS  = DEF_FLAG_BITS,
  parameter int BLOCK_MASK = DEF_BLOCK_MASK,
  parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  cmd_t                                                  cmd,
  output stat_t                                                 stat,
  input  logic                                                  cfg_we,
  input  logic [2:0]                                            cfg_index,
  input  logic [31:0]                                           cfg_data,
  input  logic [15:0]                                           cell_addr,
  input  logic [15:0]                                           cell_flag,
  input  logic signed [31:0]                                    origin_x,
  input  logic signed [31:0]                                    origin_y,
  input  logic signed [31:0]                                    origin_z,
  input  logic signed [31:0]                                    dir_x,
  input  logic signed [31:0]                                    dir_z,
  input  logic [30:0]                                           ray_length,
  output logic                                                  ram_we,
  output logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] ram_waddr,
  output logic [FLAG_BITS-1:0]                                  ram_wdata,
  output logic                                                  ram_re,
  output logic [((MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1)-1:0] ram_raddr,
  input  logic [FLAG_BITS-1:0]                                  ram_rdata,
  output logic                                                  hit,
  output logic signed [31:0]                                    hit_x,
  output logic signed [31:0]                                    hit_y,
  output logic signed [31:0]                                    hit_z
);

  localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int RW   = AW + 1;
  localparam bit POW2 = (MAX_CELLS > 1) && ((MAX_CELLS & (MAX_CELLS - 1)) == 0);
  localparam int SW   = $clog2(MAX_STEPS + 1);

  logic [8:0]         cells_x, cells_z;
  logic [30:0]        cell_size;
  logic signed [31:0] min_x, min_y, min_z, scale_x, scale_z;

  logic signed [31:0] ox, oy, oz, dx, dz;
  logic [30:0]        len;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [48:0] prod_fl;

  logic signed [31:0] gx, gz;
  logic signed [32:0] dist_left, dist_left_next;
  logic [SW-1:0]      steps, steps_next;
  logic [8:0]         nx, nz, ix, iz;
  logic [SUM_W-1:0]   asum, asum_sh;
  logic [AW-1:0]      rem, rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x   <= 9'd1;
      cells_z   <= 9'd1;
      cell_size <= 31'd65536;
      min_x     <= '0;
      min_y     <= '0;
      min_z     <= '0;
      scale_x   <= 32'sd65536;
      scale_z   <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS_X:   cells_x   <= cfg_data[8:0];
        REG_CELLS_Z:   cells_z   <= cfg_data[8:0];
        REG_CELL_SIZE: cell_size <= cfg_data[30:0];
        REG_MIN_X:     min_x     <= cfg_data;
        REG_MIN_Y:     min_y     <= cfg_data;
        REG_MIN_Z:     min_z     <= cfg_data;
        REG_SCALE_X:   scale_x   <= cfg_data;
        REG_SCALE_Z:   scale_z   <= cfg_data;
        default:       cells_x   <= cells_x;
      endcase
    end
  end

  assign ram_we    = cmd.load && (32'(cell_addr) < 32'(MAX_CELLS));
  assign ram_waddr = AW'(cell_addr);
  assign ram_wdata = FLAG_BITS'(cell_flag);
  assign ram_re    = cmd.rd;
  assign ram_raddr = POW2 ? AW'(asum) : rem;

  assign nx = (cells_x == 9'd0) ? 9'd1 : cells_x;
  assign nz = (cells_z == 9'd0) ? 9'd1 : cells_z;

  always_comb begin
    if (cmd.mul_x) begin
      mul_a = 33'(ox) - 33'(min_x);
      mul_b = scale_x;
    end else if (cmd.mul_z) begin
      mul_a = 33'(oz) - 33'(min_z);
      mul_b = scale_z;
    end else if (cmd.hx) begin
      mul_a = $signed({2'b00, cell_size});
      mul_b = gx;
    end else begin
      mul_a = $signed({2'b00, cell_size});
      mul_b = gz;
    end
  end

  assign prod_fl = $signed(prod[64:16]);

  assign dist_left_next = dist_left - $signed({2'b00, cell_size});
  assign steps_next     = SW'(steps + 1'b1);

  always_comb begin
    logic [RW-1:0]    t;
    logic [AW-1:0]    r;
    logic [SUM_W-1:0] sh;
    r  = rem;
    sh = asum;
    for (int k = 0; k < MOD_STEP; k++) begin
      t  = {r, sh[SUM_W-1]};
      sh = {sh[SUM_W-2:0], 1'b0};
      if (t >= RW'(MAX_CELLS)) begin
        t = t - RW'(MAX_CELLS);
      end
      r = t[AW-1:0];
    end
    rem_next = r;
    asum_sh  = sh;
  end

  assign stat.short_ray = (ray_length < 31'(EPS_Q16));
  assign stat.blocked   = |(ram_rdata & FLAG_BITS'(BLOCK_MASK));
  assign stat.first     = (steps == '0);
  assign stat.walk_end  = dist_left_next[32] || (steps_next == SW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ox  <= origin_x;
      oy  <= origin_y;
      oz  <= origin_z;
      dx  <= dir_x;
      dz  <= dir_z;
      len <= ray_length;
    end
    if (cmd.mul_x || cmd.mul_z || cmd.hx || cmd.hz) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_z) begin
      gx <= sat32(50'(prod_fl));
    end
    if (cmd.set_z) begin
      gz        <= sat32(50'(prod_fl));
      dist_left <= $signed({2'b00, len}) + 33'(EPS_Q16);
      steps     <= '0;
    end
    if (cmd.idx) begin
      ix <= cell_idx(gx, nx);
      iz <= cell_idx(gz, nz);
    end
    if (cmd.adr) begin
      asum <= SUM_W'(ix) + SUM_W'(iz) * SUM_W'(nx);
      rem  <= '0;
    end
    if (cmd.mod) begin
      asum <= asum_sh;
      rem  <= rem_next;
    end
    if (cmd.step) begin
      dist_left <= dist_left_next;
      steps     <= steps_next;
      gx        <= sat32(50'(gx) + 50'(dx));
      gz        <= sat32(50'(gz) + 50'(dz));
    end
    if (cmd.res_miss) begin
      hit   <= 1'b0;
      hit_x <= '0;
      hit_y <= '0;
      hit_z <= '0;
    end
    if (cmd.res_orig) begin
      hit   <= 1'b1;
      hit_x <= ox;
      hit_y <= oy;
      hit_z <= oz;
    end
    if (cmd.hz) begin
      hit_x <= sat32(50'(prod_fl) + 50'(min_x));
    end
    if (cmd.res_hit) begin
      hit   <= 1'b1;
      hit_y <= min_y;
      hit_z <= sat32(50'(prod_fl) + 50'(min_z));
    end
  end

endmodule

FILE: src/grid_ray_march_passability_top.sv
// Top level of the grid ray-march block: controller, datapath and flag table
//
// One command channel: a word is taken at a clock edge where start is high
// and busy is low. mode 0 writes cell_flag into the flag table at cell_addr
// in that cycle and leaves the block free for the next word at once.
// mode 1 casts a ray: the block raises busy (not for a cast shorter than
// the threshold) and, when the walk ends, shows hit, hit_x, hit_y and hit_z
// for one cycle with done high; the receiver must take that word then, it
// cannot stall the block. A cast shorter than the threshold answers in the
// cycle after it is taken. Otherwise a cast runs grid mapping, then per cell
// visited index, address, table read and check, with an address reduction
// before the read when the table depth is not a power of two; a hit past
// the first cell adds hit x, hit z and finish. One read per cell; the walk is
// bounded by MAX_STEPS cells. Configuration writes are registered; the user
// must make them only while busy is low, the block does not enforce this.
// rst is synchronous: it returns the block to idle and the configuration
// registers to their reset values; the result registers and the flag table
// keep their contents, and the table holds nothing defined until written.
module grid_ray_march_passability_top
  import grmp_pkg::*;
#(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int FLAG_BITS  = DEF_FLAG_BITS,
  parameter int BLOCK_MASK = DEF_BLOCK_MASK,
  parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [15:0]        cell_addr,
  input  logic [15:0]        cell_flag,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        ray_length,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  cmd_t                 cmd;
  stat_t                stat;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [FLAG_BITS-1:0] ram_wdata, ram_rdata;

  grmp_ctrl #(
    .MAX_CELLS(MAX_CELLS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (mode),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  grmp_dp #(
    .MAX_CELLS (MAX_CELLS),
    .FLAG_BITS (FLAG_BITS),
    .BLOCK_MASK(BLOCK_MASK),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_addr (cell_addr),
    .cell_flag (cell_flag),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .origin_z  (origin_z),
    .dir_x     (dir_x),
    .dir_z     (dir_z),
    .ray_length(ray_length),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .hit       (hit),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z)
  );

  grmp_ram #(
    .WIDTH(FLAG_BITS),
    .DEPTH(MAX_CELLS)
  ) u_flag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `ASSERT_SAME(a_done_idle, done, !busy, "result word issued while walk still running")
  `ASSERT_NEXT(a_busy_from_cast, !busy && !(start && mode), !busy, "busy rose without a cast")
  `ASSERT_SAME(a_load_idle, ram_we, !busy && start && !mode, "table write outside a load")
  `ASSERT_SAME(a_read_busy, ram_re, busy, "table read while idle")

endmodule

FILE: dv/tb_grid_ray_march_passability_top.sv
// Testbench for the grid ray-march block: random flag loads and ray casts against a march predictor
module tb_grid_ray_march_passability_top;
  import grmp_pkg::*;

  localparam logic   MODE_LOAD   = 1'b0;
  localparam logic   MODE_CAST   = 1'b1;
  localparam longint S32_HI      = 64'sd2147483647;
  localparam longint S32_LO      = -64'sd2147483648;
  localparam longint LEN_MAX     = 64'sd2147483647;
  localparam longint TIMEOUT_CYC = 150000000;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_WORDS = 210;
  localparam int     FILL_CELLS  = 256;

  typedef struct {
    logic               mode;
    logic [15:0]        addr;
    logic [15:0]        flag;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dz;
    logic [30:0]        len;
    int                 gap;
  } grid_word_t;

  typedef struct {
    logic               is_hit;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } hit_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               mode = MODE_LOAD;
  logic [15:0]        cell_addr = '0;
  logic [15:0]        cell_flag = '0;
  logic signed [31:0] origin_x = '0;
  logic signed [31:0] origin_y = '0;
  logic signed [31:0] origin_z = '0;
  logic signed [31:0] dir_x = '0;
  logic signed [31:0] dir_z = '0;
  logic [30:0]        ray_length = '0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_CELLS_X;
  logic [31:0]        cfg_data = '0;
  logic               done;
  logic               hit;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;

  logic [15:0]        flag_mem [0:DEF_MAX_CELLS-1];
  logic [8:0]         nx_cfg;
  logic [8:0]         nz_cfg;
  logic [30:0]        size_cfg;
  logic signed [31:0] min_x_cfg;
  logic signed [31:0] min_y_cfg;
  logic signed [31:0] min_z_cfg;
  logic signed [31:0] scale_x_cfg;
  logic signed [31:0] scale_z_cfg;

  grid_word_t  pending_words[$];
  hit_report_t expected_hits[$];
  grid_word_t  cur_word;
  logic        taken = 1'b0;
  int          idle_left = 0;
  int          mismatches = 0;

  grid_ray_march_passability_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > S32_HI) return 32'sh7fff_ffff;
    if (v < S32_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic int unsigned grid_cell(longint pos, logic [8:0] count);
    longint n;
    longint c;
    n = (count == 0) ? 1 : longint'(count);
    if (pos < 0) return 0;
    c = pos >>> 16;
    if (c >= n) c = n - 1;
    return int'(c);
  endfunction

  function automatic hit_report_t march_ray(grid_word_t w);
    hit_report_t r;
    longint      gx;
    longint      gz;
    longint      dist_left;
    int unsigned steps;
    int unsigned nx;
    int unsigned a;
    logic        blocked;
    logic        walking;
    r = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
    if (w.len < EPS_Q16) return r;
    nx = (nx_cfg == 0) ? 1 : nx_cfg;
    gx = clip32(((longint'(w.ox) - longint'(min_x_cfg)) * longint'(scale_x_cfg)) >>> 16);
    gz = clip32(((longint'(w.oz) - longint'(min_z_cfg)) * longint'(scale_z_cfg)) >>> 16);
    dist_left = longint'(w.len) + EPS_Q16;
    steps = 0;
    blocked = 1'b0;
    walking = 1'b1;
    while (walking) begin
      a = (grid_cell(gx, nx_cfg) + grid_cell(gz, nz_cfg) * nx) % DEF_MAX_CELLS;
      if ((flag_mem[a] & 16'(DEF_BLOCK_MASK)) != 0) begin
        blocked = 1'b1;
        walking = 1'b0;
      end else begin
        dist_left = dist_left - longint'(size_cfg);
        gx = clip32(gx + longint'(w.dx));
        gz = clip32(gz + longint'(w.dz));
        steps++;
        if (dist_left < 0 || steps >= DEF_MAX_STEPS) walking = 1'b0;
      end
    end
    if (blocked) begin
      r.is_hit = 1'b1;
      if (steps == 0) begin
        r.x = w.ox;
        r.y = w.oy;
        r.z = w.oz;
      end else begin
        r.x = clip32(((longint'(size_cfg) * gx) >>> 16) + longint'(min_x_cfg));
        r.y = min_y_cfg;
        r.z = clip32(((longint'(size_cfg) * gz) >>> 16) + longint'(min_z_cfg));
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_flag(int blk_pct);
    logic [15:0] f;
    f = 16'($urandom);
    if ($urandom_range(0, 99) < blk_pct) f = f | 16'(DEF_BLOCK_MASK);
    else f = f & ~16'(DEF_BLOCK_MASK);
    return f;
  endfunction

  task automatic push_load(logic [15:0] a, logic [15:0] f, int gap);
    grid_word_t w;
    w.mode = MODE_LOAD;
    w.addr = a;
    w.flag = f;
    w.ox = $urandom;
    w.oy = $urandom;
    w.oz = $urandom;
    w.dx = $urandom;
    w.dz = $urandom;
    w.len = 31'($urandom);
    w.gap = gap;
    pending_words.push_back(w);
  endtask

  task automatic push_cast(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] oz, logic signed [31:0] dx,
                           logic signed [31:0] dz, logic [30:0] len, int gap);
    grid_word_t w;
    w.mode = MODE_CAST;
    w.addr = 16'($urandom);
    w.flag = 16'($urandom);
    w.ox = ox;
    w.oy = oy;
    w.oz = oz;
    w.dx = dx;
    w.dz = dz;
    w.len = len;
    w.gap = gap;
    pending_words.push_back(w);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CELLS_X:   nx_cfg = data[8:0];
      REG_CELLS_Z:   nz_cfg = data[8:0];
      REG_CELL_SIZE: size_cfg = data[30:0];
      REG_MIN_X:     min_x_cfg = data;
      REG_MIN_Y:     min_y_cfg = data;
      REG_MIN_Z:     min_z_cfg = data;
      REG_SCALE_X:   scale_x_cfg = data;
      REG_SCALE_Z:   scale_z_cfg = data;
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [31:0] c_x, logic [31:0] c_z, logic [31:0] c_size,
                            logic [31:0] m_x, logic [31:0] m_y, logic [31:0] m_z,
                            logic [31:0] s_x, logic [31:0] s_z);
    cfg_write(REG_CELLS_X, c_x);
    cfg_write(REG_CELLS_Z, c_z);
    cfg_write(REG_CELL_SIZE, c_size);
    cfg_write(REG_MIN_X, m_x);
    cfg_write(REG_MIN_Y, m_y);
    cfg_write(REG_MIN_Z, m_z);
    cfg_write(REG_SCALE_X, s_x);
    cfg_write(REG_SCALE_Z, s_z);
  endtask

  // hold until every word is taken and every cast has answered
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || start || busy || expected_hits.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, hit_report_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t (%s): expected hit %0b x %h y %h z %h, got hit %0b x %h y %h z %h",
               $time, what, want.is_hit, want.x, want.y, want.z, hit, hit_x, hit_y, hit_z);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else begin
        cur_word = pending_words.pop_front();
        idle_left <= cur_word.gap;
        start <= 1'b1;
        mode <= cur_word.mode;
        cell_addr <= cur_word.addr;
        cell_flag <= cur_word.flag;
        origin_x <= cur_word.ox;
        origin_y <= cur_word.oy;
        origin_z <= cur_word.oz;
        dir_x <= cur_word.dx;
        dir_z <= cur_word.dz;
        ray_length <= cur_word.len;
      end
    end
  end

  always @(posedge clk) begin
    hit_report_t want;
    taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_hits.size() == 0) begin
          want = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
          note_mismatch("no cast pending", want);
        end else begin
          want = expected_hits.pop_front();
          if (hit !== want.is_hit || hit_x !== want.x || hit_y !== want.y ||
              hit_z !== want.z)
            note_mismatch("cast result", want);
        end
      end
      if (start && !busy) begin
        taken = 1'b1;
        if (cur_word.mode == MODE_LOAD) flag_mem[cur_word.addr] = cur_word.flag;
        else expected_hits.push_back(march_ray(cur_word));
      end
    end
  end

  initial begin
    #(TIMEOUT_CYC * 10);
    $display("Verification failed");
    $finish;
  end

  initial begin
    longint cx;
    longint cz;
    longint csz;
    longint mnx;
    longint mnz;
    longint scx;
    longint scz;
    longint gpx;
    longint gpz;
    longint ln;
    int     blk_pct;
    int     g;
    bit     wild;
    bit     gaps_on;
    nx_cfg = 9'd1;
    nz_cfg = 9'd1;
    size_cfg = 31'd65536;
    min_x_cfg = '0;
    min_y_cfg = '0;
    min_z_cfg = '0;
    scale_x_cfg = 32'sd65536;
    scale_z_cfg = 32'sd65536;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // load every cell that a grid of up to FILL_CELLS cells can reach
    for (int a = 0; a < FILL_CELLS; a++) push_load(16'(a), rand_flag(15), 0);
    wait_idle();

    // directed: 4x4 grid, unit cells and scale
    write_regs(4, 4, 65536, 0, 32'h1234_0000, 0, 65536, 65536);
    push_load(16'd0, 16'hffff, pick_gap());
    push_cast(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 31'h7fff_ffff, pick_gap());
    push_cast(0, 0, 0, 0, 0, 31'd0, pick_gap());
    push_cast(0, 0, 0, 0, 0, 31'(EPS_Q16 - 1), pick_gap());
    push_load(16'd0, 16'hfffd, pick_gap());
    push_load(16'd5, 16'h0002, pick_gap());
    push_load(16'd10, 16'h0000, pick_gap());
    push_load(16'd15, 16'h0002, pick_gap());
    push_cast(0, 32'sh0001_0000, 0, 32'sd65536, 32'sd65536, 31'h000a_0000, pick_gap());
    push_cast(0, 0, 0, 32'sd65536, 32'sd65536, 31'(EPS_Q16), pick_gap());
    push_cast(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 31'h0005_0000, pick_gap());
    push_cast(0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 31'h000a_0000, pick_gap());
    push_cast(0, 0, 0, 0, 0, 31'h7fff_ffff, pick_gap());
    push_cast(32'sh0002_8000, 0, 32'sh0001_8000, -32'sd32768, 32'sd16384, 31'h0003_0000,
              pick_gap());
    wait_idle();

    // zero cell counts act as one cell; zero cell size runs into the step limit
    write_regs(0, 0, 0, 0, $urandom, 0, 65536, 65536);
    push_load(16'd0, 16'hfffd, pick_gap());
    push_cast($urandom, $urandom, $urandom, $urandom, $urandom, 31'h0005_0000, pick_gap());
    push_load(16'd0, 16'h0002, pick_gap());
    push_cast($urandom, $urandom, $urandom, $urandom, $urandom, 31'h0005_0000, pick_gap());
    wait_idle();
    write_regs(0, 0, 1, $urandom, $urandom, $urandom, 65536, 65536);
    push_load(16'd0, 16'h0000, pick_gap());
    push_cast($urandom, $urandom, $urandom, $urandom, $urandom, 31'(EPS_Q16), pick_gap());
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      wild = (p >= 6);
      gaps_on = (p != 4);
      blk_pct = $urandom_range(5, 25);
      case (p)
        1: begin
          cx = 256;
          cz = 1;
        end
        2: begin
          cx = 1;
          cz = 256;
        end
        3: begin
          cx = 16;
          cz = 16;
        end
        default: begin
          cx = wild ? $urandom_range(1, 256) : $urandom_range(1, 24);
          cz = $urandom_range(1, 32'(FILL_CELLS / cx));
        end
      endcase
      if (!wild) begin
        csz = $urandom_range(0, 1) ? 65536 : $urandom_range(16384, 262144);
        mnx = longint'($urandom_range(0, 33554432)) - 16777216;
        mnz = longint'($urandom_range(0, 33554432)) - 16777216;
        case ($urandom_range(0, 2))
          0: scx = 32768;
          1: scx = 65536;
          default: scx = 131072;
        endcase
        case ($urandom_range(0, 2))
          0: scz = 32768;
          1: scz = 65536;
          default: scz = 131072;
        endcase
        write_regs(32'(cx), 32'(cz), 32'(csz), 32'(mnx), $urandom, 32'(mnz),
                   32'(scx), 32'(scz));
      end else if (p == 6) begin
        csz = LEN_MAX;
        write_regs(32'(cx), 32'(cz), 32'(csz), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h7fff_ffff);
      end else begin
        csz = $urandom_range(1, 32'h7fff_ffff);
        write_regs(32'(cx), 32'(cz), 32'(csz), $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        g = gaps_on ? pick_gap() : 0;
        if ($urandom_range(0, 99) < 35) begin
          if ($urandom_range(0, 9) < 7)
            push_load(16'($urandom_range(0, 32'(cx - 1)) +
                          $urandom_range(0, 32'(cz - 1)) * cx), rand_flag(blk_pct), g);
          else
            push_load(16'($urandom), rand_flag(blk_pct), g);
        end else if (wild || $urandom_range(0, 9) == 0) begin
          ln = csz * $urandom_range(0, 24) + $urandom_range(0, 32'(csz - 1));
          if (ln > LEN_MAX) ln = LEN_MAX;
          push_cast($urandom, $urandom, $urandom, $urandom, $urandom, 31'(ln), g);
        end else begin
          gpx = longint'($urandom_range(0, 32'((cx + 2) * 65536))) - 65536;
          gpz = longint'($urandom_range(0, 32'((cz + 2) * 65536))) - 65536;
          ln = csz * $urandom_range(0, 40) + $urandom_range(0, 65535);
          if (ln > LEN_MAX) ln = LEN_MAX;
          push_cast(32'(mnx + (gpx * 65536) / scx), $urandom, 32'(mnz + (gpz * 65536) / scz),
                    32'(longint'($urandom_range(0, 196608)) - 98304),
                    32'(longint'($urandom_range(0, 196608)) - 98304), 31'(ln), g);
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
